>>> sv/bqr_pkg.sv
// Package: shared types, codes and defaults of the broadcast queue.
package bqr_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int READERS_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT_ON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT    = 2'd2;

  typedef enum logic [2:0] {
    OP_POST    = 3'd0,
    OP_RECV    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_DRAIN   = 3'd3,
    OP_SUB     = 3'd4,
    OP_UNSUB   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SIZE    = 3'd1,
    ST_NOREAD  = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_NOSLOT  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_CONF = 2'd1,
    K_OPP  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RECV_DATA,
    S_REL_WR,
    S_RA_RD,
    S_RA_WR,
    S_RECL,
    S_OPP_CHK,
    S_OPP_WR,
    S_OPP_CONT,
    S_POP_RD,
    S_POP_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic post;
    logic sub;
    logic set_empty;
    logic recv_start;
    logic recv_out;
    logic rel_rd;
    logic drop_p;
    logic drop_cur;
    logic opp_init;
    logic opp_first;
    logic opp_next;
    logic rd_head;
    logic pop;
    logic unsub_fin;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic rid_ok;
    logic kind_some;
    logic recv_empty;
    logic rel_ok;
    logic rcopy;
    logic cur_caught;
    logic cur_last;
    logic opp_go;
    logic opp_sel;
    logic opp_match;
    logic count_nz;
    logic refs_zero;
  } stat_t;

endpackage

>>> sv/bqr_datapath.sv
// Datapath: ring memories, reader table, counters and result registers.
module bqr_datapath #(
  parameter int DEPTH   = bqr_pkg::DEPTH_DEF,
  parameter int READERS = bqr_pkg::READERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bqr_pkg::cmd_t                   cmd,
  output bqr_pkg::stat_t                  st,
  input  logic [2:0]                      in_req_type,
  input  logic [2:0]                      in_reader_id,
  input  logic [63:0]                     in_payload,
  input  logic [15:0]                     in_msg_size,
  input  logic                            in_by_copy,
  input  logic                            in_receive_copy,
  input  logic [15:0]                     in_buffer_size,
  input  logic [5:0]                      in_handle,
  input  logic                            in_opportunist,
  input  logic                            cfg_we,
  input  logic [bqr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bqr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [2:0]                      out_status,
  output logic [63:0]                     out_payload,
  output logic [15:0]                     out_size,
  output logic [5:0]                      out_handle,
  output logic [2:0]                      out_assigned_reader,
  output logic [6:0]                      out_queue_count,
  output logic                            out_space_freed
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RID_W = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int REF_W = $clog2(READERS + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
    ring_next = (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // configuration
  logic [6:0]  dlim_r;
  logic        slim_on_r;
  logic [15:0] slim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlim_r    <= 7'd64;
      slim_on_r <= 1'b0;
      slim_r    <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        bqr_pkg::CFG_DEPTH_LIMIT:   dlim_r    <= cfg_data[6:0];
        bqr_pkg::CFG_SIZE_LIMIT_ON: slim_on_r <= cfg_data[0];
        bqr_pkg::CFG_SIZE_LIMIT:    slim_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // request registers
  bqr_pkg::op_t     op_r;
  logic [RID_W-1:0] rid_r;
  logic             rid_ok_r;
  logic [63:0]      pay_in_r;
  logic [15:0]      msize_r;
  logic             bycopy_r;
  logic             rcopy_r;
  logic [15:0]      buf_r;
  logic [5:0]       hdl_r;
  logic             opp_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= bqr_pkg::op_t'(in_req_type);
      rid_r    <= RID_W'(in_reader_id);
      rid_ok_r <= (32'(in_reader_id) < READERS);
      pay_in_r <= in_payload;
      msize_r  <= in_msg_size;
      bycopy_r <= in_by_copy;
      rcopy_r  <= in_receive_copy;
      buf_r    <= in_buffer_size;
      hdl_r    <= in_handle;
      opp_r    <= in_opportunist;
    end
  end

  // ring state
  logic [IDX_W-1:0] head_r, tail_r, p_r;
  logic [CNT_W-1:0] cnt_r;
  logic [REF_W-1:0] total_r, opp_total_r;
  logic [REF_W-1:0] start_r;
  logic             first_r;
  logic [RID_W-1:0] cur_r;

  bqr_pkg::kind_t   kind_r   [READERS];
  logic [IDX_W-1:0] pos_r    [READERS];
  logic             caught_r [READERS];

  logic [REF_W-1:0] refs_mem [DEPTH];
  logic [63:0]      pay_mem  [DEPTH];
  logic [15:0]      size_mem [DEPTH];
  logic [REF_W-1:0] refs_rd_r;
  logic [63:0]      pay_rd_r;
  logic [15:0]      size_rd_r;

  logic [IDX_W-1:0] pos_cur, nxt_pos, hdl_idx, rd_addr;
  logic             adv_catch, full, hdl_in, post_wr;
  logic [IDX_W:0]   off;
  logic [REF_W-1:0] refs_dec;
  bqr_pkg::status_t post_st;
  logic             free_found;
  logic [RID_W-1:0] free_idx;

  assign pos_cur   = pos_r[cur_r];
  assign nxt_pos   = ring_next(pos_cur);
  assign adv_catch = (nxt_pos == tail_r) || (cnt_r == '0);
  assign hdl_idx   = IDX_W'(hdl_r);
  assign hdl_in    = (32'(hdl_r) < DEPTH);
  assign off       = (hdl_idx >= head_r) ? ({1'b0, hdl_idx} - {1'b0, head_r})
                   : ({1'b0, hdl_idx} + (IDX_W+1)'(DEPTH) - {1'b0, head_r});
  assign full      = (CMP_W'(cnt_r) >= CMP_W'(dlim_r)) || (CMP_W'(cnt_r) >= CMP_W'(DEPTH));
  assign refs_dec  = (refs_rd_r == '0) ? '0 : refs_rd_r - 1'b1;
  assign rd_addr   = cmd.rd_head ? head_r : (cmd.rel_rd ? hdl_idx : pos_cur);

  always_comb begin
    if (slim_on_r && (msize_r > slim_r))  post_st = bqr_pkg::ST_SIZE;
    else if (total_r == '0)                post_st = bycopy_r ? bqr_pkg::ST_OK
                                                              : bqr_pkg::ST_NOREAD;
    else if (full)                         post_st = bqr_pkg::ST_FULL;
    else                                   post_st = bqr_pkg::ST_OK;
  end

  assign post_wr = cmd.post && (post_st == bqr_pkg::ST_OK) && (total_r != '0);

  // lowest free reader slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int r = READERS - 1; r >= 0; r--) begin
      if (kind_r[r] == bqr_pkg::K_NONE) begin
        free_found = 1'b1;
        free_idx   = RID_W'(r);
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (post_wr) begin
      pay_mem[tail_r]  <= pay_in_r;
      size_mem[tail_r] <= msize_r;
    end
    if (cmd.recv_start) begin
      pay_rd_r  <= pay_mem[pos_cur];
      size_rd_r <= size_mem[pos_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (post_wr)           refs_mem[tail_r]  <= total_r;
    else if (cmd.drop_p)   refs_mem[p_r]     <= refs_dec;
    else if (cmd.drop_cur) refs_mem[pos_cur] <= refs_dec;
    refs_rd_r <= refs_mem[rd_addr];
  end

  // pointers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      opp_total_r <= '0;
      cur_r       <= '0;
      first_r     <= 1'b0;
    end else begin
      if (post_wr) begin
        tail_r <= ring_next(tail_r);
        cnt_r  <= cnt_r + 1'b1;
      end
      if (cmd.pop) begin
        head_r <= ring_next(head_r);
        cnt_r  <= cnt_r - 1'b1;
      end
      if (cmd.sub && free_found) begin
        total_r <= total_r + 1'b1;
        if (opp_r) opp_total_r <= opp_total_r + 1'b1;
      end
      if (cmd.unsub_fin) begin
        if (kind_r[rid_r] == bqr_pkg::K_OPP && opp_total_r != '0)
          opp_total_r <= opp_total_r - 1'b1;
        if (total_r != '0) total_r <= total_r - 1'b1;
      end
      if (cmd.latch)         cur_r <= RID_W'(in_reader_id);
      else if (cmd.opp_init) cur_r <= '0;
      else if (cmd.opp_next) cur_r <= cur_r + 1'b1;
      if (cmd.opp_first)     first_r <= 1'b1;
      else if (cmd.drop_cur) first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.recv_start) p_r <= pos_cur;
    else if (cmd.rel_rd) p_r <= hdl_idx;
    if (cmd.drop_cur && first_r) start_r <= refs_rd_r;
  end

  // reader table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < READERS; r++) begin
        kind_r[r]   <= bqr_pkg::K_NONE;
        pos_r[r]    <= '0;
        caught_r[r] <= 1'b1;
      end
    end else begin
      if (post_wr) begin
        for (int r = 0; r < READERS; r++) begin
          if (kind_r[r] != bqr_pkg::K_NONE && caught_r[r]) begin
            pos_r[r]    <= tail_r;
            caught_r[r] <= 1'b0;
          end
        end
      end
      if (cmd.sub && free_found) begin
        kind_r[free_idx]   <= opp_r ? bqr_pkg::K_OPP : bqr_pkg::K_CONF;
        caught_r[free_idx] <= 1'b1;
        pos_r[free_idx]    <= '0;
      end
      if (cmd.recv_start || cmd.drop_cur) begin
        if (adv_catch) caught_r[cur_r] <= 1'b1;
        else           pos_r[cur_r]    <= nxt_pos;
      end
      if (cmd.unsub_fin) kind_r[rid_r] <= bqr_pkg::K_NONE;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_status      <= bqr_pkg::ST_OK;
      out_space_freed <= 1'b0;
    end else if (cmd.latch) begin
      out_status      <= bqr_pkg::ST_OK;
      out_space_freed <= 1'b0;
    end else begin
      if (cmd.post)      out_status <= post_st;
      if (cmd.set_empty) out_status <= bqr_pkg::ST_EMPTY;
      if (cmd.sub)       out_status <= free_found ? bqr_pkg::ST_OK : bqr_pkg::ST_NOSLOT;
      if (cmd.recv_out && rcopy_r && (size_rd_r > buf_r)) out_status <= bqr_pkg::ST_SIZE;
      if (cmd.pop)       out_space_freed <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      out_payload         <= '0;
      out_size            <= '0;
      out_handle          <= '0;
      out_assigned_reader <= '0;
    end else begin
      if (cmd.sub && free_found) out_assigned_reader <= 3'(free_idx);
      if (cmd.recv_out) begin
        out_size <= size_rd_r;
        if (!rcopy_r) begin
          out_payload <= pay_rd_r;
          out_handle  <= 6'(p_r);
        end else if (size_rd_r <= buf_r) begin
          out_payload <= pay_rd_r;
        end
      end
    end
  end

  assign out_queue_count = 7'(cnt_r);

  // status to the controller
  always_comb begin
    st.op         = op_r;
    st.rid_ok     = rid_ok_r;
    st.kind_some  = rid_ok_r && (kind_r[rid_r] != bqr_pkg::K_NONE);
    st.recv_empty = !rid_ok_r || caught_r[rid_r] || (cnt_r == '0);
    st.rel_ok     = hdl_in && (off < (IDX_W+1)'(cnt_r));
    st.rcopy      = rcopy_r;
    st.cur_caught = caught_r[cur_r];
    st.cur_last   = (cur_r == RID_W'(READERS - 1));
    st.opp_go     = (opp_total_r != '0) && full && (cnt_r != '0);
    st.opp_sel    = (kind_r[cur_r] == bqr_pkg::K_OPP) && !caught_r[cur_r]
                    && (pos_cur == head_r);
    st.opp_match  = first_r || (refs_rd_r == start_r);
    st.count_nz   = (cnt_r != '0);
    st.refs_zero  = (refs_rd_r == '0);
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= DEPTH)
    else $error("entry count beyond ring depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop && !post_wr) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("pop did not drop the entry count");

  a_post_room: assert property (@(posedge clk) disable iff (!rst_n)
    post_wr |-> !full)
    else $error("entry written into a full ring");

endmodule

>>> sv/bqr_ctrl.sv
// Controller: sequences each request over the datapath.
module bqr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  bqr_pkg::stat_t st,
  output bqr_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_valid
);

  bqr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bqr_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bqr_pkg::S_IDLE: begin
        if (start) state_nxt = bqr_pkg::S_DISPATCH;
      end
      bqr_pkg::S_DISPATCH: begin
        case (st.op)
          bqr_pkg::OP_RECV:    state_nxt = st.recv_empty ? bqr_pkg::S_DONE
                                                         : bqr_pkg::S_RECV_DATA;
          bqr_pkg::OP_RELEASE: state_nxt = st.rel_ok ? bqr_pkg::S_REL_WR : bqr_pkg::S_RECL;
          bqr_pkg::OP_DRAIN:   state_nxt = st.rid_ok ? bqr_pkg::S_RA_RD : bqr_pkg::S_DONE;
          bqr_pkg::OP_UNSUB:   state_nxt = st.kind_some ? bqr_pkg::S_RA_RD : bqr_pkg::S_DONE;
          default:             state_nxt = bqr_pkg::S_DONE;
        endcase
      end
      bqr_pkg::S_RECV_DATA: state_nxt = st.rcopy ? bqr_pkg::S_RECL : bqr_pkg::S_DONE;
      bqr_pkg::S_REL_WR:    state_nxt = bqr_pkg::S_RECL;
      bqr_pkg::S_RA_RD:     state_nxt = st.cur_caught ? bqr_pkg::S_RECL : bqr_pkg::S_RA_WR;
      bqr_pkg::S_RA_WR:     state_nxt = bqr_pkg::S_RA_RD;
      bqr_pkg::S_RECL:      state_nxt = st.opp_go ? bqr_pkg::S_OPP_CHK : bqr_pkg::S_POP_RD;
      bqr_pkg::S_OPP_CHK: begin
        if (st.opp_sel)       state_nxt = bqr_pkg::S_OPP_WR;
        else if (st.cur_last) state_nxt = bqr_pkg::S_POP_RD;
      end
      bqr_pkg::S_OPP_WR: begin
        if (st.opp_match)     state_nxt = bqr_pkg::S_OPP_CONT;
        else if (st.cur_last) state_nxt = bqr_pkg::S_POP_RD;
        else                  state_nxt = bqr_pkg::S_OPP_CHK;
      end
      bqr_pkg::S_OPP_CONT: begin
        if (!st.cur_caught)   state_nxt = bqr_pkg::S_OPP_WR;
        else if (st.cur_last) state_nxt = bqr_pkg::S_POP_RD;
        else                  state_nxt = bqr_pkg::S_OPP_CHK;
      end
      bqr_pkg::S_POP_RD:  state_nxt = st.count_nz ? bqr_pkg::S_POP_CHK : bqr_pkg::S_DONE;
      bqr_pkg::S_POP_CHK: state_nxt = st.refs_zero ? bqr_pkg::S_POP_RD : bqr_pkg::S_DONE;
      bqr_pkg::S_DONE:    state_nxt = bqr_pkg::S_IDLE;
      default:            state_nxt = bqr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = (state_r != bqr_pkg::S_IDLE);
    out_valid = (state_r == bqr_pkg::S_DONE);
    case (state_r)
      bqr_pkg::S_IDLE: cmd.latch = start;
      bqr_pkg::S_DISPATCH: begin
        case (st.op)
          bqr_pkg::OP_POST: cmd.post = 1'b1;
          bqr_pkg::OP_SUB:  cmd.sub  = 1'b1;
          bqr_pkg::OP_RECV: begin
            cmd.set_empty  = st.recv_empty;
            cmd.recv_start = !st.recv_empty;
          end
          bqr_pkg::OP_RELEASE: cmd.rel_rd = st.rel_ok;
          default: ;
        endcase
      end
      bqr_pkg::S_RECV_DATA: begin
        cmd.recv_out = 1'b1;
        cmd.drop_p   = st.rcopy;
      end
      bqr_pkg::S_REL_WR: cmd.drop_p   = 1'b1;
      bqr_pkg::S_RA_WR:  cmd.drop_cur = 1'b1;
      bqr_pkg::S_RECL:   cmd.opp_init = st.opp_go;
      bqr_pkg::S_OPP_CHK: begin
        cmd.opp_first = st.opp_sel;
        cmd.opp_next  = !st.opp_sel && !st.cur_last;
      end
      bqr_pkg::S_OPP_WR: begin
        cmd.drop_cur = st.opp_match;
        cmd.opp_next = !st.opp_match && !st.cur_last;
      end
      bqr_pkg::S_OPP_CONT: cmd.opp_next = st.cur_caught && !st.cur_last;
      bqr_pkg::S_POP_RD:   cmd.rd_head  = 1'b1;
      bqr_pkg::S_POP_CHK:  cmd.pop      = st.refs_zero;
      bqr_pkg::S_DONE:     cmd.unsub_fin = (st.op == bqr_pkg::OP_UNSUB) && st.kind_some;
      default: ;
    endcase
  end

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bqr_pkg::S_IDLE && start) |=> (state_r == bqr_pkg::S_DISPATCH))
    else $error("accepted item not dispatched");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

endmodule

>>> sv/broadcast_queue_refcount.sv
// Top level: broadcast queue with per-entry reader reference counts.
//
// Usage: raise start with a request on the in_ ports; it is taken as an item
// at a clock edge where busy is low. busy stays high until the result item
// appears on the out_ ports for exactly one cycle with out_valid high; the
// receiver cannot stall, so the result is gone after that cycle.
// Each item passes through dispatch and then delivery; a receive by handle
// also reads the entry from the ring. Requests that reclaim (copy receive,
// release, drain, unsubscribe) go on to the reclaim pass: a release of an
// occupied slot first drops its reference count, a drain or unsubscribe
// drops the count of each entry the reader still holds, a scan over the
// readers skips entries for opportunists that are behind on a full queue,
// and entries whose count is zero are popped from the head. The walk over
// the shared reference-count memory port sets the length of each request.
// One item at a time; the next is taken in the cycle after out_valid.
// Configuration: cfg_valid/cfg_ready write depth_limit, size_limit_on and
// size_limit by index; cfg_ready is always high. Write only while idle.
// Reset (rst_n low, synchronous) empties the ring, drops all readers and
// restores the register defaults; no clearing pass is needed.
module broadcast_queue_refcount #(
  parameter int DEPTH   = bqr_pkg::DEPTH_DEF,
  parameter int READERS = bqr_pkg::READERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_req_type,
  input  logic [2:0]                      in_reader_id,
  input  logic [63:0]                     in_payload,
  input  logic [15:0]                     in_msg_size,
  input  logic                            in_by_copy,
  input  logic                            in_receive_copy,
  input  logic [15:0]                     in_buffer_size,
  input  logic [5:0]                      in_handle,
  input  logic                            in_opportunist,
  output logic                            out_valid,
  output logic [2:0]                      out_status,
  output logic [63:0]                     out_payload,
  output logic [15:0]                     out_size,
  output logic [5:0]                      out_handle,
  output logic [2:0]                      out_assigned_reader,
  output logic [6:0]                      out_queue_count,
  output logic                            out_space_freed,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bqr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bqr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bqr_pkg::cmd_t  cmd;
  bqr_pkg::stat_t st;

  // take configuration writes in any cycle
  assign cfg_ready = 1'b1;

  // sequence each item: dispatch, reader walks, reclaim, deliver
  bqr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // hold the ring, reader table and result item
  bqr_datapath #(
    .DEPTH   (DEPTH),
    .READERS (READERS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_req_type         (in_req_type),
    .in_reader_id        (in_reader_id),
    .in_payload          (in_payload),
    .in_msg_size         (in_msg_size),
    .in_by_copy          (in_by_copy),
    .in_receive_copy     (in_receive_copy),
    .in_buffer_size      (in_buffer_size),
    .in_handle           (in_handle),
    .in_opportunist      (in_opportunist),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_status          (out_status),
    .out_payload         (out_payload),
    .out_size            (out_size),
    .out_handle          (out_handle),
    .out_assigned_reader (out_assigned_reader),
    .out_queue_count     (out_queue_count),
    .out_space_freed     (out_space_freed)
  );

endmodule
